>>> rtl/bqn_pkg.sv
package bqn_pkg;

  localparam int COEF_W      = 24;
  localparam int HIST_W      = 44;
  localparam int HIST_FRAC   = 16;
  localparam int SLICE_W     = 24;
  localparam int ROUND_SHIFT = 32;
  localparam int CNT_W       = 4;
  localparam int IDX_W       = 3;

  localparam logic signed [COEF_W-1:0] GAIN_Q16 = 24'sd62259;

  localparam logic signed [COEF_W-1:0] B0_RESET = 24'sd524293;
  localparam logic signed [COEF_W-1:0] B1_RESET = 24'sd1048576;
  localparam logic signed [COEF_W-1:0] B2_RESET = 24'sd524283;
  localparam logic signed [COEF_W-1:0] A1_RESET = -24'sd1048576;
  localparam logic signed [COEF_W-1:0] A2_RESET = 24'sd0;

  localparam logic [IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [IDX_W-1:0] REG_A2 = 3'd4;

  localparam logic [CNT_W-1:0] STEP_MUL_LAST   = 4'd4;
  localparam logic [CNT_W-1:0] STEP_COMB_FIRST = 4'd1;
  localparam logic [CNT_W-1:0] STEP_COMB_LAST  = 4'd5;
  localparam logic [CNT_W-1:0] STEP_ACC_FIRST  = 4'd2;
  localparam logic [CNT_W-1:0] STEP_ACC_LAST   = 4'd6;
  localparam logic [CNT_W-1:0] STEP_SAT        = 4'd7;
  localparam logic [CNT_W-1:0] STEP_GAIN       = 4'd8;
  localparam logic [CNT_W-1:0] STEP_COMB_GAIN  = 4'd9;
  localparam logic [CNT_W-1:0] STEP_OUT        = 4'd10;

  typedef enum logic [2:0] {
    SEL_B0,
    SEL_B1,
    SEL_B2,
    SEL_A1,
    SEL_A2,
    SEL_GAIN
  } coef_sel_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic      load;
    logic      mul_en;
    coef_sel_t sel;
    logic      comb_en;
    logic      acc_en;
    logic      sat_en;
    logic      out_en;
  } cmd_t;

endpackage

>>> rtl/biquad_notch_filter.sv
// Each accepted sample runs through the five filter products, the history update and the
// 0.95 output gain, formed one after another by the shared 24x25 multiplier pair; its result
// is then loaded into the output register once free. No new sample is taken before that.
// The next sample is taken while the previous result still waits in the output register.
// Reset (synchronous, active high): coefficients to their defaults, history cleared,
// output register empty.
module biquad_notch_filter import bqn_pkg::*; #(
  parameter int COEF_FRAC_BITS = 20,
  parameter int SAMPLE_BITS    = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          clipped,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [IDX_W-1:0]              cfg_index,
  input  logic [COEF_W-1:0]             cfg_data
);

  cmd_t cmd;

  bqn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  bqn_datapath #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (sample_in),
    .sample_out (sample_out),
    .clipped    (clipped)
  );

`ifndef NO_ASSERTIONS
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_en |-> !(out_valid && out_stall))
    else $error("output register overwritten while a beat waits");

  a_first_term: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (cmd.mul_en && cmd.sel == SEL_B0))
    else $error("accepted sample did not start with the b0 product");

  a_gain_after_sat: assert property (@(posedge clk) disable iff (rst)
    cmd.sat_en |=> (cmd.mul_en && cmd.sel == SEL_GAIN))
    else $error("output gain product did not follow history update");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_en))
    else $error("result beat appeared without an output load");
`endif

endmodule

>>> rtl/bqn_ctrl.sv
module bqn_ctrl import bqn_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output logic cfg_ready,
  output cmd_t cmd
);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid_next;
  logic             out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (in_valid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt == STEP_OUT) begin
          if (out_free) begin
            state_next = ST_IDLE;
            cnt_next   = '0;
          end
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.sel   = SEL_B0;
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cfg_ready = 1'b1;
        cmd.load  = in_valid;
      end
      ST_RUN: begin
        if (cnt <= STEP_MUL_LAST) begin
          cmd.mul_en = 1'b1;
          cmd.sel    = coef_sel_t'(cnt[2:0]);
        end
        if (cnt == STEP_GAIN) begin
          cmd.mul_en = 1'b1;
          cmd.sel    = SEL_GAIN;
        end
        cmd.comb_en = (cnt >= STEP_COMB_FIRST && cnt <= STEP_COMB_LAST)
                      || cnt == STEP_COMB_GAIN;
        cmd.acc_en  = cnt >= STEP_ACC_FIRST && cnt <= STEP_ACC_LAST;
        cmd.sat_en  = cnt == STEP_SAT;
        cmd.out_en  = cnt == STEP_OUT && out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (cmd.out_en) begin
      out_valid_next = 1'b1;
    end
  end

endmodule

>>> rtl/bqn_datapath.sv
module bqn_datapath import bqn_pkg::*; #(
  parameter int COEF_FRAC_BITS = 20,
  parameter int SAMPLE_BITS    = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cmd_t                          cmd,
  input  logic                          cfg_we,
  input  logic [IDX_W-1:0]              cfg_index,
  input  logic [COEF_W-1:0]             cfg_data,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          clipped
);

  localparam int OPW   = (SAMPLE_BITS + HIST_FRAC > HIST_W) ? SAMPLE_BITS + HIST_FRAC : HIST_W;
  localparam int MUL_W = COEF_W + SLICE_W + 1;
  localparam int PW    = COEF_W + OPW;
  localparam int TW    = PW - COEF_FRAC_BITS;
  localparam int YW    = (TW + 3 > HIST_W + 1) ? TW + 3 : HIST_W + 1;
  localparam int SW    = PW - ROUND_SHIFT;
  localparam logic signed [PW-1:0] RND_HALF = PW'(64'h8000_0000);

  logic signed [COEF_W-1:0]      coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic signed [SAMPLE_BITS-1:0] x_cur, x1, x2;
  logic signed [HIST_W-1:0]      y1, y2;
  logic hist_clr;

  logic signed [COEF_W-1:0]  coef_op;
  logic signed [OPW-1:0]     v_op;
  logic signed [SLICE_W:0]   op_lo, op_hi;
  logic signed [MUL_W-1:0]   p_lo, p_hi;
  logic signed [PW-1:0]      prod;
  logic signed [TW-1:0]      term;
  logic signed [YW-1:0]      yacc;
  logic                      y_fits;
  logic signed [HIST_W-1:0]  ysat;
  logic signed [PW-1:0]      rsum;
  logic signed [SW-1:0]      s_val;
  logic                      s_fits;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= B0_RESET;
      coef_b1 <= B1_RESET;
      coef_b2 <= B2_RESET;
      coef_a1 <= A1_RESET;
      coef_a2 <= A2_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_B0:  coef_b0 <= cfg_data;
        REG_B1:  coef_b1 <= cfg_data;
        REG_B2:  coef_b2 <= cfg_data;
        REG_A1:  coef_a1 <= cfg_data;
        REG_A2:  coef_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    hist_clr = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        REG_B0, REG_B1, REG_B2, REG_A1, REG_A2: hist_clr = 1'b1;
        default: hist_clr = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || hist_clr) begin
      x1 <= '0;
      x2 <= '0;
      y1 <= '0;
      y2 <= '0;
    end else if (cmd.sat_en) begin
      x1 <= x_cur;
      x2 <= x1;
      y1 <= ysat;
      y2 <= y1;
    end
  end

  always_comb begin
    case (cmd.sel)
      SEL_B0: begin
        coef_op = coef_b0;
        v_op    = OPW'(x_cur) <<< HIST_FRAC;
      end
      SEL_B1: begin
        coef_op = coef_b1;
        v_op    = OPW'(x1) <<< HIST_FRAC;
      end
      SEL_B2: begin
        coef_op = coef_b2;
        v_op    = OPW'(x2) <<< HIST_FRAC;
      end
      SEL_A1: begin
        coef_op = coef_a1;
        v_op    = OPW'(y1);
      end
      SEL_A2: begin
        coef_op = coef_a2;
        v_op    = OPW'(y2);
      end
      SEL_GAIN: begin
        coef_op = GAIN_Q16;
        v_op    = OPW'(y1);
      end
      default: begin
        coef_op = '0;
        v_op    = '0;
      end
    endcase
  end

  // low slice unsigned, high slice signed
  assign op_lo = {1'b0, v_op[SLICE_W-1:0]};
  assign op_hi = (SLICE_W + 1)'($signed(v_op[OPW-1:SLICE_W]));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_cur <= sample_in;
    end
    if (cmd.mul_en) begin
      p_lo <= MUL_W'(coef_op) * MUL_W'(op_lo);
      p_hi <= MUL_W'(coef_op) * MUL_W'(op_hi);
    end
    if (cmd.comb_en) begin
      prod <= (PW'(p_hi) <<< SLICE_W) + PW'(p_lo);
    end
  end

  assign term = $signed(prod[PW-1:COEF_FRAC_BITS]);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      yacc <= '0;
    end else if (cmd.acc_en) begin
      yacc <= yacc + YW'(term);
    end
  end

  assign y_fits = (&yacc[YW-1:HIST_W-1]) | ~(|yacc[YW-1:HIST_W-1]);
  assign ysat   = y_fits ? yacc[HIST_W-1:0] : {yacc[YW-1], {(HIST_W-1){~yacc[YW-1]}}};

  assign rsum   = prod + RND_HALF;
  assign s_val  = $signed(rsum[PW-1:ROUND_SHIFT]);
  assign s_fits = (&s_val[SW-1:SAMPLE_BITS-1]) | ~(|s_val[SW-1:SAMPLE_BITS-1]);

  always_ff @(posedge clk) begin
    if (cmd.out_en) begin
      sample_out <= s_fits ? s_val[SAMPLE_BITS-1:0]
                           : {s_val[SW-1], {(SAMPLE_BITS-1){~s_val[SW-1]}}};
      clipped    <= !s_fits;
    end
  end

endmodule
